### hdl/rfdw_pkg.sv
package rfdw_pkg;

  // Frame header bytes '@', '^', 'r'
  localparam logic [7:0] HDR0 = 8'h40;
  localparam logic [7:0] HDR1 = 8'h5E;
  localparam logic [7:0] HDR2 = 8'h72;

  // Frame layout: positions 0..9, checksum at the last one
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_HDR0   = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR1   = 4'd1;
  localparam logic [POS_W-1:0] POS_HDR2   = 4'd2;
  localparam logic [POS_W-1:0] POS_ANG_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_ANG_LO = 4'd4;
  localparam logic [POS_W-1:0] POS_DST_HI = 4'd5;
  localparam logic [POS_W-1:0] POS_DST_LO = 4'd6;
  localparam logic [POS_W-1:0] FRAME_LAST = 4'd9;

  // Window limit registers
  localparam int LIM_W  = 16;
  localparam int CIDX_W = 3;

  typedef enum logic [CIDX_W-1:0] {
    REG_ANGLE_LOW  = 3'd0,
    REG_ANGLE_HIGH = 3'd1,
    REG_DIST_LOW   = 3'd2,
    REG_DIST_HIGH  = 3'd3
  } reg_idx_t;

  localparam logic [LIM_W-1:0] ANGLE_LOW_RST  = 16'd240;
  localparam logic [LIM_W-1:0] ANGLE_HIGH_RST = 16'd300;
  localparam logic [LIM_W-1:0] DIST_LOW_RST   = 16'd10;
  localparam logic [LIM_W-1:0] DIST_HIGH_RST  = 16'd4000;

endpackage

### hdl/range_frame_decoder_with_window.sv
// Range frame decoder with window check. Received bytes enter on the in_
// channel at up to one item per clock; the parser hunts for the '@' '^' 'r'
// header, collects a 10-byte frame (big-endian angle in bytes 3-4, distance
// in bytes 5-6, 8-bit sum of bytes 0-8 in byte 9) and, for a frame whose
// checksum matches, delivers one item with angle, distance and in_window
// (both values inside the inclusive cfg limits) on out_: the checksum
// byte is parsed out of the input register straight into the result
// register once the result slot is free or draining. Header mismatches
// are dropped in place, a bad checksum drops the frame. Throughput is one
// byte per clock, limited only by the combinational parse step between the
// two registers; while a result waits for out_ready the parse step holds,
// so at most one further byte is taken into the input register until the
// result leaves. Limit registers are written through cfg_we/cfg_index/
// cfg_wdata by the user only while idle; the block does not enforce it.
module range_frame_decoder_with_window
  import rfdw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // byte input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_angle,
  output logic [15:0]             out_distance,
  output logic                    out_in_window,
  // limit register writes
  input  logic                    cfg_we,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [LIM_W-1:0]        cfg_wdata
);

  // Limit registers
  logic [LIM_W-1:0] ang_lo_r, ang_hi_r, dst_lo_r, dst_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_lo_r <= ANGLE_LOW_RST;
      ang_hi_r <= ANGLE_HIGH_RST;
      dst_lo_r <= DIST_LOW_RST;
      dst_hi_r <= DIST_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_LOW:  ang_lo_r <= cfg_wdata;
        REG_ANGLE_HIGH: ang_hi_r <= cfg_wdata;
        REG_DIST_LOW:   dst_lo_r <= cfg_wdata;
        REG_DIST_HIGH:  dst_hi_r <= cfg_wdata;
        default: ;      // unknown index: ignored
      endcase
    end
  end

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_fire;
  logic       out_valid_r;

  // the parse step moves only when the result slot is free or draining
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Parser state
  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       sum_r, sum_nxt, sum_cur;
  logic [7:0]       ang_hi_b_r, ang_lo_b_r, dst_hi_b_r, dst_lo_b_r;
  logic             hdr_ok;
  logic             result_nxt;
  logic [15:0]      angle_w, dist_w;
  logic             win_w;

  assign angle_w = {ang_hi_b_r, ang_lo_b_r};
  assign dist_w  = {dst_hi_b_r, dst_lo_b_r};
  assign win_w   = (angle_w >= ang_lo_r) && (angle_w <= ang_hi_r) &&
                   (dist_w >= dst_lo_r) && (dist_w <= dst_hi_r);

  // one parse step for the byte in the input register
  always_comb begin
    // a stray position is handled as the frame start with a zero sum
    pos_cur    = (pos_r > FRAME_LAST) ? POS_HDR0 : pos_r;
    sum_cur    = (pos_r > FRAME_LAST) ? 8'h00 : sum_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    result_nxt = 1'b0;
    unique case (pos_cur)
      POS_HDR0: hdr_ok = (s1_byte_r == HDR0);
      POS_HDR1: hdr_ok = (s1_byte_r == HDR1);
      POS_HDR2: hdr_ok = (s1_byte_r == HDR2);
      default:  hdr_ok = 1'b1;
    endcase
    if (s1_fire) begin
      priority if (!hdr_ok) begin
        pos_nxt = pos_cur;
        sum_nxt = sum_cur;
      end else if (pos_cur != FRAME_LAST) begin
        pos_nxt = pos_cur + 1'b1;
        sum_nxt = sum_cur + s1_byte_r;
      end else begin
        // checksum byte: restart either way
        result_nxt = (s1_byte_r == sum_cur);
        pos_nxt    = POS_HDR0;
        sum_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HDR0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Payload byte capture
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (pos_cur == POS_ANG_HI) ang_hi_b_r <= s1_byte_r;
      if (pos_cur == POS_ANG_LO) ang_lo_b_r <= s1_byte_r;
      if (pos_cur == POS_DST_HI) dst_hi_b_r <= s1_byte_r;
      if (pos_cur == POS_DST_LO) dst_lo_b_r <= s1_byte_r;
    end
  end

  // Result register
  logic [15:0] angle_r, dist_r;
  logic        win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= result_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && result_nxt) begin
      angle_r <= angle_w;
      dist_r  <= dist_w;
      win_r   <= win_w;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_angle     = angle_r;
  assign out_distance  = dist_r;
  assign out_in_window = win_r;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= FRAME_LAST)
    else $error("frame position out of range");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && pos_r == FRAME_LAST) |=> (pos_r == POS_HDR0 && sum_r == '0))
    else $error("parser did not restart after checksum byte");

  a_no_result_midframe: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && pos_r != FRAME_LAST) |=> !out_valid_r || $past(out_valid_r))
    else $error("result raised on a non-checksum byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

endmodule

### verif/range_frame_decoder_with_window_tb.sv
`timescale 1ns / 100ps

module range_frame_decoder_with_window_tb;
  import rfdw_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // covers the two-stage result path
  localparam int DRAIN_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BYTES   = 170;
  localparam logic [CIDX_W-1:0] REG_SPARE_FIRST = CIDX_W'(REG_DIST_HIGH) + 1'b1;
  localparam logic [CIDX_W-1:0] REG_SPARE_LAST  = {CIDX_W{1'b1}};

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] distance;
    logic        in_window;
  } range_result_t;

  // Frame parser shadow plus the queue of results it predicts
  class window_scoreboard;
    logic [LIM_W-1:0] ang_lo, ang_hi, dst_lo, dst_hi;
    logic [POS_W-1:0] pos;
    logic [7:0]       sum;
    logic [7:0]       field_bytes[4];
    range_result_t    pending_results[$];
    int               errors;

    function new();
      ang_lo = ANGLE_LOW_RST;
      ang_hi = ANGLE_HIGH_RST;
      dst_lo = DIST_LOW_RST;
      dst_hi = DIST_HIGH_RST;
      pos    = POS_HDR0;
      sum    = '0;
      errors = 0;
      foreach (field_bytes[i]) field_bytes[i] = '0;
    endfunction

    function void set_limit(reg_idx_t idx, logic [LIM_W-1:0] v);
      case (idx)
        REG_ANGLE_LOW:  ang_lo = v;
        REG_ANGLE_HIGH: ang_hi = v;
        REG_DIST_LOW:   dst_lo = v;
        REG_DIST_HIGH:  dst_hi = v;
        default: ;
      endcase
    endfunction

    // One accepted byte through the parser
    function void note_byte(logic [7:0] b);
      range_result_t r;
      logic [15:0]   ang, dst;
      if (pos > FRAME_LAST) begin
        pos = POS_HDR0;
        sum = '0;
      end
      // header mismatch: drop, stay put
      if ((pos == POS_HDR0 && b != HDR0) || (pos == POS_HDR1 && b != HDR1) ||
          (pos == POS_HDR2 && b != HDR2))
        return;
      if (pos < FRAME_LAST) begin
        if (pos >= POS_ANG_HI && pos <= POS_DST_LO)
          field_bytes[2'(pos - POS_ANG_HI)] = b;
        sum = sum + b;
        pos = pos + 1'b1;
        return;
      end
      // checksum byte
      if (b == sum) begin
        ang = {field_bytes[0], field_bytes[1]};
        dst = {field_bytes[2], field_bytes[3]};
        r.angle     = ang;
        r.distance  = dst;
        r.in_window = (ang >= ang_lo) && (ang <= ang_hi) &&
                      (dst >= dst_lo) && (dst <= dst_hi);
        pending_results.push_back(r);
      end
      pos = POS_HDR0;
      sum = '0;
    endfunction

    task flag_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [15:0] ang, logic [15:0] dst, logic win);
      range_result_t want;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result angle %0d distance %0d", ang, dst));
        return;
      end
      want = pending_results.pop_front();
      if (ang !== want.angle)
        flag_error($sformatf("angle %0d, wanted %0d", ang, want.angle));
      if (dst !== want.distance)
        flag_error($sformatf("distance %0d, wanted %0d", dst, want.distance));
      if (win !== want.in_window)
        flag_error($sformatf("in_window %b, wanted %b (angle %0d distance %0d)",
                             win, want.in_window, want.angle, want.distance));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_rx_byte;
  logic             out_valid;
  logic             out_ready;
  logic [15:0]      out_angle;
  logic [15:0]      out_distance;
  logic             out_in_window;
  logic             cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [LIM_W-1:0] cfg_wdata;

  window_scoreboard sb;
  bit               steady;    // no idling on either side
  bit               hold_req;  // asks the receiver for one long hold-off
  int               byte_count;

  range_frame_decoder_with_window dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_angle     (out_angle),
    .out_distance  (out_distance),
    .out_in_window (out_in_window),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result sampling
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_angle, out_distance, out_in_window);
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    byte_count++;
    @(negedge clk);
  endtask

  // Full frame; optional junk inside the header, optional bad checksum
  task automatic send_frame(input logic [15:0] ang, input logic [15:0] dst,
                            input bit good, input bit junk_header);
    logic [7:0] body[9];
    logic [7:0] csum;
    body = '{HDR0, HDR1, HDR2, ang[15:8], ang[7:0], dst[15:8], dst[7:0],
             8'($urandom), 8'($urandom)};
    csum = '0;
    foreach (body[i]) begin
      if (junk_header && (i == 1 || i == 2))
        send_byte(body[i] ^ 8'($urandom_range(1, 255)));
      csum = csum + body[i];
      send_byte(body[i]);
    end
    if (!good)
      csum = csum + 8'($urandom_range(1, 255));
    send_byte(csum);
  endtask

  // Walk the parser back to the start of a frame
  task automatic resync();
    while (sb.pos != POS_HDR0) begin
      if (sb.pos == POS_HDR1)
        send_byte(HDR1);
      else if (sb.pos == POS_HDR2)
        send_byte(HDR2);
      else
        send_byte(8'($urandom));
    end
  endtask

  // Stop sending and let every pending result drain
  task automatic wait_results();
    int n;
    n = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all four limits, then a spare index that must be ignored
  task automatic load_limits(input logic [15:0] al, input logic [15:0] ah,
                             input logic [15:0] dl, input logic [15:0] dh);
    logic [15:0] vals[4];
    vals = '{al, ah, dl, dh};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      sb.set_limit(reg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_index <= CIDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
    cfg_wdata <= 16'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Value biased toward the limit edges and the field extremes
  function automatic logic [15:0] pick_value(input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: v = lo + 16'($urandom_range(0, 2)) - 16'd1;
      1: v = hi + 16'($urandom_range(0, 2)) - 16'd1;
      2: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3, 4: begin
        if (lo <= hi)
          v = lo + 16'($urandom % (int'(hi) - int'(lo) + 1));
        else
          v = 16'($urandom);
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_frame(input bit good, input bit junk_header);
    send_frame(pick_value(sb.ang_lo, sb.ang_hi), pick_value(sb.dst_lo, sb.dst_hi),
               good, junk_header);
  endtask

  // Mostly well-formed frames, some noise and broken ones
  task automatic run_phase(input int n_bytes, input bit pressure);
    int stop_at;
    stop_at = byte_count + n_bytes;
    while (byte_count < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
          resync();
        end
        1: random_frame(1'b0, 1'b0);
        2: random_frame(1'b1, 1'b1);
        default: random_frame(1'b1, 1'b0);
      endcase
    end
    if (pressure) begin
      // results back up behind a stalled receiver until input stalls
      hold_req = 1'b1;
      repeat (25) random_frame(1'b1, 1'b0);
      wait_results();
      repeat (5) random_frame(1'b1, 1'b0);
    end
    wait_results();
  endtask

  initial begin
    sb         = new();
    steady     = 1'b0;
    hold_req   = 1'b0;
    byte_count = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_ANGLE_LOW;
    cfg_wdata  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: noise at the header start, header junk, field extremes,
    // a good and a failing checksum
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1);
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0);
    wait_results();

    // Reset limits
    run_phase(PHASE_BYTES, 1'b0);
    // Widest window
    load_limits(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    run_phase(PHASE_BYTES, 1'b0);
    // Window pinned at zero
    load_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(PHASE_BYTES, 1'b0);
    // Window pinned at the top
    load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(PHASE_BYTES, 1'b1);
    // Crossed limits: never in window
    load_limits(16'd500, 16'd100, 16'd4000, 16'd10);
    run_phase(PHASE_BYTES, 1'b0);
    // An ordered window, then random limits
    load_limits(16'd200, 16'd400, 16'd1000, 16'd3000);
    run_phase(PHASE_BYTES, 1'b0);
    load_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(PHASE_BYTES, 1'b0);
    // Closing stretch at full rate
    steady = 1'b1;
    load_limits(16'd240, 16'd300, 16'd10, 16'd4000);
    run_phase(PHASE_BYTES, 1'b0);

    if (sb.pending_results.size() != 0)
      sb.flag_error($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
